[src/flux_pulse_width_capture_core_defines.svh]
// Assertion helpers shared by the capture RTL.
`ifndef FLUX_PULSE_WIDTH_CAPTURE_CORE_DEFINES_SVH
`define FLUX_PULSE_WIDTH_CAPTURE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FPWC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define FPWC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/fpwc_pkg.sv]
package fpwc_pkg;

   // result kinds
   localparam logic [1:0] KIND_PULSE   = 2'd0;
   localparam logic [1:0] KIND_INDEX   = 2'd1;
   localparam logic [1:0] KIND_TIMEOUT = 2'd2;

   // register indexes
   localparam logic REG_MAX_PULSES = 1'b0;
   localparam logic REG_TIMEOUT    = 1'b1;

   localparam logic [15:0] MAX_PULSES_RESET = 16'hFFFF;
   localparam logic [31:0] TIMEOUT_RESET    = 32'd1000000;

   // width of a pulse at its start sample
   localparam logic [7:0] WIDTH_START = 8'd4;
   localparam logic [7:0] WIDTH_MAX   = 8'd255;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  pulse_width;
      logic [15:0] pulse_total;
      logic        last;
   } result_type;

endpackage

[src/flux_pulse_width_capture_core.sv]
// Flux pulse-width capture. Each req_ transaction is either a start command
// (req_operation = 1) or one sample of the drive's data and index lines. After
// start the core waits for index low (a timeout fires once more than
// timeout_samples high index samples are seen), then for data high and data
// low, then times each flux pulse (low phase then high phase) in samples,
// starting at 4 on the pulse-start sample and saturating at 255. One rsp_
// transaction is produced per finished pulse, and a final one (rsp_last = 1)
// when index falls at a pulse start or on timeout; the pulse that reaches
// max_pulses also carries rsp_last. Each sample is handled as it is accepted: the capture
// state machine updates in the accepting cycle and the result lands in an
// output register, so one transaction per clock is sustained while req_ready is high. A two-entry
// output (register plus skid) keeps accepting while one result waits on
// rsp_ready; req_ready drops only when both entries are full. Write csr_
// registers only while idle: index 0 = max_pulses (0 acts as 1), index 1 =
// timeout_samples. csr_ready is always high.
`include "flux_pulse_width_capture_core_defines.svh"

module flux_pulse_width_capture_core (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic        req_data_level,
   input  logic        req_index_level,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_pulse_width,
   output logic [15:0] rsp_pulse_total,
   output logic        rsp_last,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   logic [15:0] max_pulses_ff;
   logic [31:0] timeout_ff;

   logic                 req_take;
   logic                 res_valid;
   fpwc_pkg::result_type res;
   fpwc_pkg::result_type rsp_data;

   // config registers, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_pulses_ff <= fpwc_pkg::MAX_PULSES_RESET;
         timeout_ff    <= fpwc_pkg::TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            fpwc_pkg::REG_MAX_PULSES: max_pulses_ff <= csr_data[15:0];
            fpwc_pkg::REG_TIMEOUT:    timeout_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign req_take = req_valid && req_ready;

   // capture state machine; result is combinational off accepted transaction
   fpwc_capture u_capture (
      .clock           (clock),
      .reset           (reset),
      .step            (req_take),
      .operation       (req_operation),
      .data_level      (req_data_level),
      .index_level     (req_index_level),
      .max_pulses      (max_pulses_ff),
      .timeout_samples (timeout_ff),
      .res_valid       (res_valid),
      .res             (res)
   );

   // output register with skid entry
   fpwc_out_skid u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res),
      .in_room   (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_kind        = rsp_data.kind;
   assign rsp_pulse_width = rsp_data.pulse_width;
   assign rsp_pulse_total = rsp_data.pulse_total;
   assign rsp_last        = rsp_data.last;

   `FPWC_ASSERT_NOW(a_result_needs_take, res_valid, req_take, "result produced without accepted transaction")
   `FPWC_ASSERT_NOW(a_skid_full_blocks, !req_ready, rsp_valid, "input blocked with empty output")
   `FPWC_ASSERT_NEXT(a_cfg_max_write, csr_valid && csr_ready && (csr_index == fpwc_pkg::REG_MAX_PULSES), max_pulses_ff == $past(csr_data[15:0]), "max_pulses write lost")

endmodule

[src/fpwc_capture.sv]
`include "flux_pulse_width_capture_core_defines.svh"

module fpwc_capture (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 operation,
   input  logic                 data_level,
   input  logic                 index_level,
   input  logic [15:0]          max_pulses,
   input  logic [31:0]          timeout_samples,
   output logic                 res_valid,
   output fpwc_pkg::result_type res
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_WAIT_INDEX,
      PH_WAIT_HIGH,
      PH_WAIT_LOW,
      PH_START,
      PH_LOW,
      PH_HIGH
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  width_ff, width_in;
   logic        prev_index_ff, prev_index_in;
   logic [15:0] emitted_ff, emitted_in;
   logic [31:0] wait_ff, wait_in;

   logic [15:0] limit;
   logic [15:0] emitted_inc;
   logic [7:0]  width_bump;

   assign limit       = (max_pulses == 16'd0) ? 16'd1 : max_pulses;
   assign emitted_inc = emitted_ff + 16'd1;
   assign width_bump  = (width_ff == fpwc_pkg::WIDTH_MAX) ? fpwc_pkg::WIDTH_MAX
                                                          : width_ff + 8'd1;

   always_comb begin
      phase_in      = phase_ff;
      width_in      = width_ff;
      prev_index_in = prev_index_ff;
      emitted_in    = emitted_ff;
      wait_in       = wait_ff;
      res_valid     = 1'b0;
      res           = '0;
      if (step) begin
         if (operation) begin
            phase_in      = PH_WAIT_INDEX;
            width_in      = 8'd0;
            prev_index_in = 1'b0;
            emitted_in    = 16'd0;
            wait_in       = 32'd0;
         end else begin
            case (phase_ff)
               PH_IDLE: begin
               end
               PH_WAIT_INDEX: begin
                  if (!index_level) begin
                     phase_in = PH_WAIT_HIGH;
                  end else if (wait_ff >= timeout_samples) begin
                     phase_in  = PH_IDLE;
                     res_valid = 1'b1;
                     res.kind  = fpwc_pkg::KIND_TIMEOUT;
                     res.last  = 1'b1;
                  end else begin
                     wait_in = wait_ff + 32'd1;
                  end
               end
               PH_WAIT_HIGH: begin
                  if (data_level) phase_in = PH_WAIT_LOW;
               end
               PH_WAIT_LOW: begin
                  if (!data_level) phase_in = PH_START;
               end
               PH_START: begin
                  prev_index_in = index_level;
                  if (prev_index_ff && !index_level) begin
                     // falling edge of index seen at pulse start: one revolution done
                     phase_in        = PH_IDLE;
                     res_valid       = 1'b1;
                     res.kind        = fpwc_pkg::KIND_INDEX;
                     res.pulse_total = emitted_ff;
                     res.last        = 1'b1;
                  end else begin
                     width_in = fpwc_pkg::WIDTH_START;
                     phase_in = data_level ? PH_HIGH : PH_LOW;
                  end
               end
               PH_LOW: begin
                  width_in = width_bump;
                  if (data_level) phase_in = PH_HIGH;
               end
               PH_HIGH: begin
                  if (data_level) begin
                     width_in = width_bump;
                  end else begin
                     emitted_in      = emitted_inc;
                     res_valid       = 1'b1;
                     res.kind        = fpwc_pkg::KIND_PULSE;
                     res.pulse_width = width_ff;
                     res.pulse_total = emitted_inc;
                     if (emitted_inc >= limit) begin
                        phase_in = PH_IDLE;
                        res.last = 1'b1;
                     end else begin
                        phase_in = PH_START;
                     end
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         width_ff      <= 8'd0;
         prev_index_ff <= 1'b0;
         emitted_ff    <= 16'd0;
         wait_ff       <= 32'd0;
      end else begin
         phase_ff      <= phase_in;
         width_ff      <= width_in;
         prev_index_ff <= prev_index_in;
         emitted_ff    <= emitted_in;
         wait_ff       <= wait_in;
      end
   end

   `FPWC_ASSERT_NEXT(a_last_goes_idle, res_valid && res.last, phase_ff == PH_IDLE, "final result did not return capture to idle")
   `FPWC_ASSERT_NEXT(a_pulse_rearms, res_valid && !res.last, phase_ff == PH_START, "non-final pulse did not rearm pulse start")
   `FPWC_ASSERT_NOW(a_pulse_min_width, res_valid && (res.kind == fpwc_pkg::KIND_PULSE), res.pulse_width >= fpwc_pkg::WIDTH_START, "pulse width below start value")
   `FPWC_ASSERT_NOW(a_timeout_phase, res_valid && (res.kind == fpwc_pkg::KIND_TIMEOUT), phase_ff == PH_WAIT_INDEX, "timeout outside index wait")

endmodule

[src/fpwc_out_skid.sv]
`include "flux_pulse_width_capture_core_defines.svh"

module fpwc_out_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  fpwc_pkg::result_type in_data,
   output logic                 in_room,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output fpwc_pkg::result_type rsp_data
);

   logic                 out_valid_ff, out_valid_in;
   fpwc_pkg::result_type out_data_ff, out_data_in;
   logic                 skid_valid_ff, skid_valid_in;
   fpwc_pkg::result_type skid_data_ff, skid_data_in;

   // upstream only needs the skid entry free; out register may be stalled
   assign in_room   = !skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_ready || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_data_in  = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   `FPWC_ASSERT_NOW(a_skid_behind_out, skid_valid_ff, out_valid_ff, "skid entry held with empty output register")
   `FPWC_ASSERT_NEXT(a_stall_fills_skid, in_valid && out_valid_ff && !rsp_ready, skid_valid_ff, "stalled result not parked in skid")
   `FPWC_ASSERT_NEXT(a_skid_drains, skid_valid_ff && rsp_ready, rsp_valid && !skid_valid_ff, "skid entry not moved to output")

endmodule

[bench/tb_top.sv]
`default_nettype none

// Flux pulse-width capture bench.
//
// A short directed table runs first: an idle tick, timeout with a zero budget,
// a pulse limit of zero, a restart in mid-capture, and an index-ended capture
// under the largest timeout. Then random captures run under nine register
// settings in three handshake regimes. Every accepted transaction goes through
// a local capture predictor, and each rsp_ transaction is checked in order
// against the queue of predicted results.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // req_operation codes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_START  = 1'b1;

   localparam int RESET_CYCLES      = 12;
   // a short pause after the results drain covers any work still in flight
   // before a register write
   localparam int SETTLE_CYCLES     = 4;
   localparam int TAIL_CYCLES       = 16;
   // longest run of cycles with no transaction on any channel
   localparam int WATCHDOG_LIMIT    = 2000;
   localparam int ITEMS_PER_SETTING = 190;
   localparam int MAX_REPORTS       = 10;
   localparam int NUM_DIRECTED      = 24;

   // capture phases of the predictor
   typedef enum logic [2:0] {
      CAP_IDLE,
      CAP_WAIT_INDEX,
      CAP_WAIT_HIGH,
      CAP_WAIT_LOW,
      CAP_START,
      CAP_LOW,
      CAP_HIGH
   } capture_phase_type;

   // one row of the directed table: a register write or a line sample,
   // optionally with its result typed in
   typedef struct packed {
      logic                 is_cfg;
      logic                 cfg_index;
      logic [31:0]          cfg_value;
      logic                 op;
      logic                 data_lv;
      logic                 index_lv;
      logic                 typed;
      fpwc_pkg::result_type want;
   } step_row_type;

   // ------------------------------------------------------------------
   // clock, reset and DUT ports (all inputs known from time zero)
   // ------------------------------------------------------------------
   logic        clock           = 1'b0;
   logic        reset           = 1'b1;

   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic        req_operation   = OP_SAMPLE;
   logic        req_data_level  = 1'b0;
   logic        req_index_level = 1'b0;

   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_pulse_width;
   logic [15:0] rsp_pulse_total;
   logic        rsp_last;

   logic        csr_valid       = 1'b0;
   logic        csr_ready;
   logic        csr_index       = fpwc_pkg::REG_MAX_PULSES;
   logic [31:0] csr_data        = '0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   flux_pulse_width_capture_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_data_level  (req_data_level),
      .req_index_level (req_index_level),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_pulse_width (rsp_pulse_width),
      .rsp_pulse_total (rsp_pulse_total),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // ------------------------------------------------------------------
   // capture predictor: registers and state mirror the block after reset
   // ------------------------------------------------------------------
   logic [15:0]       pulse_limit_cfg = fpwc_pkg::MAX_PULSES_RESET;
   logic [31:0]       timeout_cfg     = fpwc_pkg::TIMEOUT_RESET;
   capture_phase_type cap_phase       = CAP_IDLE;
   logic [7:0]        width_count     = '0;
   logic              prev_index      = 1'b0;
   logic [15:0]       pulses_emitted  = '0;
   logic [31:0]       index_wait      = '0;

   fpwc_pkg::result_type pending_results [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int fail_count    = 0;
   int quiet_cycles  = 0;

   // random stimulus state: a long pulse is steered past saturation
   bit long_pulse = 1'b0;
   int pulse_run  = 0;

   function automatic logic [7:0] bump_width(input logic [7:0] w);
      return (w == fpwc_pkg::WIDTH_MAX) ? w : w + 8'd1;
   endfunction

   // Advance the predictor by one accepted transaction. Returns 1 when the
   // transaction yields a result.
   function automatic bit predict_capture(input logic op, input logic d,
                                          input logic i,
                                          output fpwc_pkg::result_type res);
      logic [15:0] limit;
      logic        prior;
      res   = '0;
      limit = (pulse_limit_cfg == 16'd0) ? 16'd1 : pulse_limit_cfg;
      if (op == OP_START) begin
         // restart from any phase; line levels are don't-care
         cap_phase      = CAP_WAIT_INDEX;
         width_count    = '0;
         prev_index     = 1'b0;
         pulses_emitted = '0;
         index_wait     = '0;
         return 1'b0;
      end
      case (cap_phase)
         CAP_IDLE: ;
         CAP_WAIT_INDEX: begin
            if (!i) begin
               cap_phase = CAP_WAIT_HIGH;
            end else if (index_wait >= timeout_cfg) begin
               // budget used up: one more high index sample times out
               cap_phase = CAP_IDLE;
               res.kind  = fpwc_pkg::KIND_TIMEOUT;
               res.last  = 1'b1;
               return 1'b1;
            end else begin
               index_wait = index_wait + 32'd1;
            end
         end
         CAP_WAIT_HIGH: if (d) cap_phase = CAP_WAIT_LOW;
         CAP_WAIT_LOW:  if (!d) cap_phase = CAP_START;
         CAP_START: begin
            // pulse-start sample: index falling edge ends the capture
            prior      = prev_index;
            prev_index = i;
            if (prior && !i) begin
               cap_phase       = CAP_IDLE;
               res.kind        = fpwc_pkg::KIND_INDEX;
               res.pulse_total = pulses_emitted;
               res.last        = 1'b1;
               return 1'b1;
            end
            width_count = fpwc_pkg::WIDTH_START;
            cap_phase   = d ? CAP_HIGH : CAP_LOW;
         end
         CAP_LOW: begin
            width_count = bump_width(width_count);
            if (d) cap_phase = CAP_HIGH;
         end
         CAP_HIGH: begin
            if (d) begin
               width_count = bump_width(width_count);
            end else begin
               // falling data ends the pulse; this low sample is not counted
               pulses_emitted  = pulses_emitted + 16'd1;
               res.kind        = fpwc_pkg::KIND_PULSE;
               res.pulse_width = width_count;
               res.pulse_total = pulses_emitted;
               res.last        = (pulses_emitted >= limit);
               cap_phase       = res.last ? CAP_IDLE : CAP_START;
               return 1'b1;
            end
         end
         default: cap_phase = CAP_IDLE;
      endcase
      return 1'b0;
   endfunction

   // ------------------------------------------------------------------
   // directed table builders
   // ------------------------------------------------------------------
   function automatic step_row_type sample_row(input logic op, input logic d,
                                               input logic i);
      step_row_type r;
      r          = '0;
      r.op       = op;
      r.data_lv  = d;
      r.index_lv = i;
      return r;
   endfunction

   function automatic step_row_type register_row(input logic idx,
                                                 input logic [31:0] val);
      step_row_type r;
      r           = '0;
      r.is_cfg    = 1'b1;
      r.cfg_index = idx;
      r.cfg_value = val;
      return r;
   endfunction

   function automatic step_row_type checked_row(input logic op, input logic d,
                                                input logic i, input logic [1:0] kind,
                                                input logic [7:0] width,
                                                input logic [15:0] total,
                                                input logic last);
      step_row_type r;
      r       = sample_row(op, d, i);
      r.typed = 1'b1;
      r.want  = '{kind, width, total, last};
      return r;
   endfunction

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------
   // Offer one transaction, wait for it to be taken, then predict it. On
   // return valid is still high; the caller either offers the next
   // transaction in the same step or drops valid.
   task automatic send_item(input logic op, input logic d, input logic i,
                            input bit typed, input fpwc_pkg::result_type typed_res,
                            output bit counted);
      fpwc_pkg::result_type res;
      bit                   got;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_data_level  <= d;
      req_index_level <= i;
      do @(posedge clock); while (!req_ready);
      // a tick while idle is dropped by the block
      counted = !(op == OP_SAMPLE && cap_phase == CAP_IDLE);
      got     = predict_capture(op, d, i, res);
      if (typed) begin
         pending_results.push_back(typed_res);
      end else if (got) begin
         pending_results.push_back(res);
      end
   endtask

   // Drop valid and let the block drain before touching registers.
   task automatic settle_block;
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == fpwc_pkg::REG_MAX_PULSES) begin
         pulse_limit_cfg = val[15:0];
      end else begin
         timeout_cfg = val;
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Pick the next random transaction. Most follow a well-formed capture
   // (index low, data high, data low, then pulses); a few are restarts or
   // random levels. Long pulses are kept clean so they reach saturation.
   task automatic pick_sample(output logic op, output logic d, output logic i);
      int  roll;
      bit  noise;
      op = OP_SAMPLE;
      d  = 1'($urandom_range(1));
      i  = 1'($urandom_range(1));
      if (cap_phase == CAP_START) begin
         long_pulse = ($urandom_range(119) == 0);
         pulse_run  = 0;
      end else if (cap_phase == CAP_LOW || cap_phase == CAP_HIGH) begin
         pulse_run++;
      end
      roll  = $urandom_range(99);
      noise = !long_pulse && roll < 6;
      if (noise) begin
         if (roll < 2) op = OP_START;
      end else begin
         case (cap_phase)
            CAP_IDLE:       if ($urandom_range(6) != 0) op = OP_START;
            CAP_WAIT_INDEX: i = ($urandom_range(2) != 0);
            CAP_WAIT_HIGH:  d = ($urandom_range(2) == 0);
            CAP_WAIT_LOW:   d = ($urandom_range(2) != 0);
            CAP_START:      i = ($urandom_range(5) == 0);
            CAP_LOW: begin
               d = long_pulse ? (pulse_run > 120 && $urandom_range(9) == 0)
                              : ($urandom_range(2) == 0);
            end
            CAP_HIGH: begin
               d = long_pulse ? !(pulse_run > 255 && $urandom_range(3) == 0)
                              : ($urandom_range(2) != 0);
            end
            default: ;
         endcase
      end
   endtask

   // Walk the capture to its end so the block is idle for register writes.
   task automatic close_capture;
      logic d;
      logic i;
      bit   took;
      while (cap_phase != CAP_IDLE) begin
         d = 1'b0;
         i = 1'b0;
         case (cap_phase)
            CAP_WAIT_HIGH, CAP_LOW: d = 1'b1;
            // raise index on one pulse start, drop it on the next
            CAP_START:              i = !prev_index;
            default: ;
         endcase
         send_item(OP_SAMPLE, d, i, 1'b0, '0, took);
      end
   endtask

   // ------------------------------------------------------------------
   // response side: random backpressure and in-order checking
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : check_results
      fpwc_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
               $display("%0t: unexpected result kind %0d width %0d total %0d last %0b",
                        $realtime, rsp_kind, rsp_pulse_width, rsp_pulse_total,
                        rsp_last);
            end
         end else begin
            want = pending_results.pop_front();
            if (rsp_kind !== want.kind || rsp_pulse_width !== want.pulse_width ||
                rsp_pulse_total !== want.pulse_total || rsp_last !== want.last) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS) begin
                  $display(
                     "%0t: exp/act kind %0d/%0d width %0d/%0d total %0d/%0d last %0b/%0b",
                     $realtime, want.kind, rsp_kind, want.pulse_width,
                     rsp_pulse_width, want.pulse_total, rsp_pulse_total,
                     want.last, rsp_last);
               end
            end
         end
      end
   end

   // watchdog: any transaction on any channel counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin : main_sequence
      step_row_type directed_steps [NUM_DIRECTED];
      logic [31:0]  limit_val;
      logic [31:0]  timeout_val;
      logic         op;
      logic         d;
      logic         i;
      bit           took;
      int           counted;
      int           setting;

      directed_steps = '{
         // tick before any start is dropped
         sample_row(OP_SAMPLE, 1'b1, 1'b1),
         // zero timeout budget: first high index sample times out
         register_row(fpwc_pkg::REG_TIMEOUT, 32'd0),
         sample_row(OP_START, 1'b1, 1'b1),
         checked_row(OP_SAMPLE, 1'b0, 1'b1, fpwc_pkg::KIND_TIMEOUT, 8'd0, 16'd0, 1'b1),
         // pulse limit of zero acts as one; upper data bits are ignored
         register_row(fpwc_pkg::REG_MAX_PULSES, 32'hFFFF_0000),
         sample_row(OP_START, 1'b0, 1'b0),
         sample_row(OP_SAMPLE, 1'b0, 1'b0),
         sample_row(OP_SAMPLE, 1'b1, 1'b1),
         sample_row(OP_SAMPLE, 1'b0, 1'b1),
         sample_row(OP_SAMPLE, 1'b0, 1'b1),
         sample_row(OP_SAMPLE, 1'b1, 1'b0),
         checked_row(OP_SAMPLE, 1'b0, 1'b0, fpwc_pkg::KIND_PULSE, 8'd5, 16'd1, 1'b1),
         // largest limit and largest timeout
         register_row(fpwc_pkg::REG_MAX_PULSES, 32'h0000_FFFF),
         register_row(fpwc_pkg::REG_TIMEOUT, 32'hFFFF_FFFF),
         sample_row(OP_START, 1'b0, 1'b1),
         sample_row(OP_SAMPLE, 1'b1, 1'b1),
         sample_row(OP_SAMPLE, 1'b0, 1'b0),
         // restart while waiting for data high
         sample_row(OP_START, 1'b1, 1'b0),
         sample_row(OP_SAMPLE, 1'b0, 1'b0),
         sample_row(OP_SAMPLE, 1'b1, 1'b0),
         sample_row(OP_SAMPLE, 1'b0, 1'b1),
         // pulse starting high: shortest width
         sample_row(OP_SAMPLE, 1'b1, 1'b1),
         checked_row(OP_SAMPLE, 1'b0, 1'b1, fpwc_pkg::KIND_PULSE, 8'd4, 16'd1, 1'b0),
         // index falls at the next pulse start
         checked_row(OP_SAMPLE, 1'b0, 1'b0, fpwc_pkg::KIND_INDEX, 8'd0, 16'd1, 1'b1)
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, no idling
      foreach (directed_steps[n]) begin
         if (directed_steps[n].is_cfg) begin
            settle_block();
            write_register(directed_steps[n].cfg_index, directed_steps[n].cfg_value);
         end else begin
            send_item(directed_steps[n].op, directed_steps[n].data_lv,
                      directed_steps[n].index_lv, directed_steps[n].typed,
                      directed_steps[n].want, took);
         end
      end
      close_capture();

      // random part: three handshake regimes, three register settings each
      for (int regime = 0; regime < 3; regime++) begin
         case (regime)
            0: begin
               send_idle_pct = 30;
               recv_idle_pct = 68;
            end
            1: begin
               send_idle_pct = 68;
               recv_idle_pct = 30;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int seg = 0; seg < 3; seg++) begin
            setting = regime * 3 + seg;
            case (setting % 4)
               0: limit_val = {16'($urandom_range(16'hFFFF)), 16'($urandom_range(1, 8))};
               1: limit_val = {16'($urandom_range(16'hFFFF)), 16'hFFFF};
               2: limit_val = {16'($urandom_range(16'hFFFF)), 16'h0000};
               default: limit_val = $urandom;
            endcase
            case (setting % 3)
               0: timeout_val = $urandom_range(4);
               1: timeout_val = 32'hFFFF_FFFF;
               default: timeout_val = $urandom;
            endcase
            settle_block();
            write_register(fpwc_pkg::REG_MAX_PULSES, limit_val);
            write_register(fpwc_pkg::REG_TIMEOUT, timeout_val);

            counted = 0;
            while (counted < ITEMS_PER_SETTING) begin
               pick_sample(op, d, i);
               send_item(op, d, i, 1'b0, '0, took);
               counted += took;
            end
            close_capture();
         end
      end

      // drain and watch for stray results
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
